// ===== hw/rtl/mhds_pkg.sv =====
package mhds_pkg;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;
	localparam logic [1:0] REQ_SORT   = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	localparam logic [3:0] OP_NONE   = 4'd0;
	localparam logic [3:0] OP_INSERT = 4'd1;
	localparam logic [3:0] OP_SCAN   = 4'd2;
	localparam logic [3:0] OP_DELSWP = 4'd3;
	localparam logic [3:0] OP_SD     = 4'd4;
	localparam logic [3:0] OP_SU     = 4'd5;
	localparam logic [3:0] OP_BUILD  = 4'd6;
	localparam logic [3:0] OP_EXTR   = 4'd7;
	localparam logic [3:0] OP_EMIT   = 4'd8;
	localparam logic [3:0] OP_START  = 4'd9;

	typedef struct packed {
		logic [3:0] op;
		logic       start;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic found;
		logic full;
		logic empty;
		logic more;
		logic multi;
	} sts_t;

endpackage

// ===== hw/rtl/max_heap_with_delete_and_sort.sv =====
// Binary max-heap of signed 32-bit values kept in a register array, one
// request beat at a time. An insert climbs the heap level by level;
// a delete scans the store entry by entry, then sifts down and then up
// level by level. A sort of two or more entries builds the heap and
// extracts every entry by root swaps and sift-downs, then emits one beat
// per entry in ascending order, with last set on the final beat.
// The request side stalls while a request is at work or its results are
// pending.
module max_heap_with_delete_and_sort #(
	parameter int DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          req_type,
	input  logic signed [31:0]  value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic signed [31:0]  item_value,
	output logic [5:0]          entry_count,
	output logic                last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1) + 1;

	mhds_pkg::cmd_t cmd;
	mhds_pkg::sts_t sts;
	logic busy;
	logic is_item;
	logic [CW-1:0] count;
	logic signed [31:0] rd_value;
	logic signed [31:0] value_q;

	assign in_stall = busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (in_valid && !in_stall) begin
			value_q <= value;
		end
	end

	mhds_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.valid_in(in_valid),
		.req_type(req_type),
		.busy(busy),
		.cmd(cmd),
		.sts(sts),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_status(status),
		.out_last(last),
		.out_is_item(is_item)
	);

	mhds_datapath #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.value(value_q),
		.sts(sts),
		.count(count),
		.rd_value(rd_value)
	);

	assign item_value = is_item ? rd_value : '0;
	assign entry_count = 6'(count);

endmodule

// ===== hw/rtl/mhds_datapath.sv =====
module mhds_datapath #(
	parameter int DEPTH = 32,
	parameter int AW = 5,
	parameter int CW = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mhds_pkg::cmd_t      cmd,
	input  logic signed [31:0]  value,
	output mhds_pkg::sts_t      sts,
	output logic [CW-1:0]       count,
	output logic signed [31:0]  rd_value
);

	logic signed [31:0] mem [DEPTH];
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] hit_q;
	logic [CW-1:0] size_q;
	logic [CW-1:0] iter_q;
	logic [CW-1:0] scan_q;
	logic signed [31:0] key_q;
	logic [2:0] ph_q;
	logic signed [31:0] a_q, b_q, c_q;
	logic [CW-1:0] big_q;
	logic done_q, found_q;

	logic [CW:0] l_w, r_w;
	logic [CW-1:0] par_w;
	logic [CW-1:0] last_w;

	assign l_w = {pos_q, 1'b1};
	assign r_w = {pos_q, 1'b0} + (CW+1)'(2);
	assign par_w = (pos_q - CW'(1)) >> 1;
	assign last_w = cnt_q - CW'(1);

	assign count = cnt_q;
	assign sts.done = done_q;
	assign sts.found = found_q;
	assign sts.full = (cnt_q >= CW'(DEPTH));
	assign sts.empty = (cnt_q == '0);
	assign sts.more = (scan_q != last_w);
	assign sts.multi = (cnt_q > CW'(1));
	assign rd_value = a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
			found_q <= 1'b0;
			ph_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				ph_q <= (cmd.op == mhds_pkg::OP_EXTR) ? 3'd5 : 3'd0;
				found_q <= 1'b0;
				unique case (cmd.op)
					mhds_pkg::OP_INSERT: begin
						mem[cnt_q[AW-1:0]] <= value;
						pos_q <= cnt_q;
						cnt_q <= cnt_q + CW'(1);
					end
					mhds_pkg::OP_SCAN: begin
						scan_q <= '0;
						key_q <= value;
					end
					mhds_pkg::OP_SU: pos_q <= hit_q;
					mhds_pkg::OP_BUILD: begin
						size_q <= cnt_q;
						iter_q <= cnt_q >> 1;
						pos_q <= (cnt_q >> 1) - CW'(1);
					end
					mhds_pkg::OP_EXTR: iter_q <= last_w;
					mhds_pkg::OP_EMIT: scan_q <= '0;
					default: ;
				endcase
			end else begin
				unique case (cmd.op)
					mhds_pkg::OP_SCAN: begin
						if (ph_q == 3'd0) begin
							a_q <= mem[scan_q[AW-1:0]];
							ph_q <= 3'd1;
						end else if (a_q == key_q) begin
							found_q <= 1'b1;
							done_q <= 1'b1;
							pos_q <= scan_q;
						end else if (scan_q + CW'(1) >= cnt_q) begin
							done_q <= 1'b1;
						end else begin
							scan_q <= scan_q + CW'(1);
							ph_q <= 3'd0;
						end
					end
					mhds_pkg::OP_DELSWP: begin
						unique case (ph_q)
							3'd0: begin
								a_q <= mem[last_w[AW-1:0]];
								ph_q <= 3'd1;
							end
							3'd1: begin
								b_q <= mem[pos_q[AW-1:0]];
								ph_q <= 3'd2;
							end
							3'd2: begin
								mem[pos_q[AW-1:0]] <= a_q;
								cnt_q <= last_w;
								size_q <= last_w;
								hit_q <= pos_q;
								found_q <= (pos_q < last_w);
								done_q <= 1'b1;
								ph_q <= 3'd3;
							end
							default: ;
						endcase
					end
					mhds_pkg::OP_SU, mhds_pkg::OP_INSERT: begin
						unique case (ph_q)
							3'd0: begin
								if (pos_q == '0) done_q <= 1'b1;
								else begin
									a_q <= mem[pos_q[AW-1:0]];
									ph_q <= 3'd1;
								end
							end
							3'd1: begin
								b_q <= mem[par_w[AW-1:0]];
								ph_q <= 3'd2;
							end
							default: begin
								if (a_q > b_q) begin
									mem[pos_q[AW-1:0]] <= b_q;
									mem[par_w[AW-1:0]] <= a_q;
									pos_q <= par_w;
									ph_q <= 3'd0;
								end else done_q <= 1'b1;
							end
						endcase
					end
					mhds_pkg::OP_SD, mhds_pkg::OP_BUILD, mhds_pkg::OP_EXTR: begin
						unique case (ph_q)
							3'd0: begin
								a_q <= mem[pos_q[AW-1:0]];
								big_q <= pos_q;
								ph_q <= 3'd1;
							end
							3'd1: begin
								if (l_w < {1'b0, size_q})
									b_q <= mem[l_w[AW-1:0]];
								ph_q <= 3'd2;
							end
							3'd2: begin
								if (l_w < {1'b0, size_q} && b_q > a_q) begin
									c_q <= b_q;
									big_q <= l_w[CW-1:0];
								end else c_q <= a_q;
								if (r_w < {1'b0, size_q})
									b_q <= mem[r_w[AW-1:0]];
								ph_q <= 3'd3;
							end
							3'd3: begin
								if (r_w < {1'b0, size_q} && b_q > c_q) begin
									c_q <= b_q;
									big_q <= r_w[CW-1:0];
								end
								ph_q <= 3'd4;
							end
							3'd4: begin
								if (big_q != pos_q) begin
									mem[pos_q[AW-1:0]] <= c_q;
									mem[big_q[AW-1:0]] <= a_q;
									pos_q <= big_q;
									ph_q <= 3'd0;
								end else if (cmd.op == mhds_pkg::OP_BUILD
									&& iter_q > CW'(1)) begin
									iter_q <= iter_q - CW'(1);
									pos_q <= iter_q - CW'(2);
									ph_q <= 3'd0;
								end else if (cmd.op != mhds_pkg::OP_EXTR) begin
									done_q <= 1'b1;
								end else begin
									ph_q <= 3'd5;
								end
							end
							3'd5: begin
								if (iter_q == '0) done_q <= 1'b1;
								else begin
									ph_q <= 3'd6;
									a_q <= mem[AW'(0)];
								end
							end
							3'd6: begin
								b_q <= mem[iter_q[AW-1:0]];
								ph_q <= 3'd7;
							end
							default: begin
								mem[AW'(0)] <= b_q;
								mem[iter_q[AW-1:0]] <= a_q;
								size_q <= iter_q;
								iter_q <= iter_q - CW'(1);
								pos_q <= '0;
								ph_q <= 3'd0;
							end
						endcase
					end
					mhds_pkg::OP_EMIT: begin
						if (ph_q == 3'd0) begin
							a_q <= mem[scan_q[AW-1:0]];
							ph_q <= 3'd1;
							done_q <= 1'b1;
						end else if (ph_q == 3'd2) begin
							scan_q <= scan_q + CW'(1);
							ph_q <= 3'd0;
						end
					end
					mhds_pkg::OP_START: ph_q <= 3'd2;
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== hw/rtl/mhds_ctrl.sv =====
module mhds_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_in,
	input  logic [1:0]          req_type,
	output logic                busy,
	output mhds_pkg::cmd_t      cmd,
	input  mhds_pkg::sts_t      sts,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [1:0]          out_status,
	output logic                out_last,
	output logic                out_is_item
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RUN  = 3'd1;
	localparam logic [2:0] S_OUT  = 3'd2;
	localparam logic [2:0] S_EOUT = 3'd3;
	localparam logic [2:0] S_EWT  = 3'd4;

	logic [2:0] state_q;
	logic [3:0] op_q;
	logic       start_q;
	logic [1:0] stat_q;
	logic       last_q;
	logic       item_q;

	assign busy = (state_q != S_IDLE);
	assign cmd.op = op_q;
	assign cmd.start = start_q;
	assign out_valid = (state_q == S_OUT) || (state_q == S_EOUT);
	assign out_status = stat_q;
	assign out_last = last_q;
	assign out_is_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= mhds_pkg::OP_NONE;
			start_q <= 1'b0;
			stat_q <= mhds_pkg::ST_OK;
			last_q <= 1'b0;
			item_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (valid_in) begin
						stat_q <= mhds_pkg::ST_OK;
						last_q <= 1'b1;
						item_q <= 1'b0;
						state_q <= S_RUN;
						start_q <= 1'b1;
						unique case (req_type)
							mhds_pkg::REQ_INSERT: begin
								if (sts.full) begin
									stat_q <= mhds_pkg::ST_FULL;
									state_q <= S_OUT;
									start_q <= 1'b0;
								end else op_q <= mhds_pkg::OP_INSERT;
							end
							mhds_pkg::REQ_DELETE: begin
								if (sts.empty) begin
									stat_q <= mhds_pkg::ST_NOTFOUND;
									state_q <= S_OUT;
									start_q <= 1'b0;
								end else op_q <= mhds_pkg::OP_SCAN;
							end
							mhds_pkg::REQ_SORT: begin
								if (sts.empty) begin
									stat_q <= mhds_pkg::ST_EMPTY;
									state_q <= S_OUT;
									start_q <= 1'b0;
								end else if (sts.multi) begin
									op_q <= mhds_pkg::OP_BUILD;
								end else begin
									op_q <= mhds_pkg::OP_EMIT;
								end
							end
							default: begin
								state_q <= S_OUT;
								start_q <= 1'b0;
							end
						endcase
					end
				end
				S_RUN: begin
					if (!start_q && sts.done) begin
						unique case (op_q)
							mhds_pkg::OP_SCAN: begin
								if (sts.found) begin
									op_q <= mhds_pkg::OP_DELSWP;
									start_q <= 1'b1;
								end else begin
									stat_q <= mhds_pkg::ST_NOTFOUND;
									state_q <= S_OUT;
								end
							end
							mhds_pkg::OP_DELSWP: begin
								if (sts.found) begin
									op_q <= mhds_pkg::OP_SD;
									start_q <= 1'b1;
								end else state_q <= S_OUT;
							end
							mhds_pkg::OP_SD: begin
								op_q <= mhds_pkg::OP_SU;
								start_q <= 1'b1;
							end
							mhds_pkg::OP_BUILD: begin
								op_q <= mhds_pkg::OP_EXTR;
								start_q <= 1'b1;
							end
							mhds_pkg::OP_EXTR: begin
								op_q <= mhds_pkg::OP_EMIT;
								start_q <= 1'b1;
							end
							mhds_pkg::OP_EMIT: begin
								item_q <= 1'b1;
								last_q <= !sts.more;
								state_q <= S_EOUT;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
						item_q <= 1'b0;
					end
				end
				S_EOUT: begin
					if (!out_stall) begin
						if (last_q) begin
							state_q <= S_IDLE;
							item_q <= 1'b0;
						end else begin
							op_q <= mhds_pkg::OP_START;
							state_q <= S_EWT;
						end
					end
				end
				default: begin
					op_q <= mhds_pkg::OP_EMIT;
					state_q <= S_RUN;
				end
			endcase
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int DEPTH = 32;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] item_value;
		logic [5:0]  entry_count;
		logic        last;
	} heap_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] req_type;
	logic signed [31:0] value;
	logic out_valid;
	logic out_stall;
	logic [1:0] status;
	logic signed [31:0] item_value;
	logic [5:0] entry_count;
	logic last;

	logic signed [31:0] shadow_heap [DEPTH];
	int shadow_fill;
	heap_result_t pending_results [$];
	int errors;
	int cycle_count;
	int stall_left;
	bit idle_enable;

	max_heap_with_delete_and_sort #(.DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .value(value), .out_valid(out_valid),
		.out_stall(out_stall), .status(status), .item_value(item_value),
		.entry_count(entry_count), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic swap_slots(input int a, input int b);
		logic signed [31:0] t;
		t = shadow_heap[a];
		shadow_heap[a] = shadow_heap[b];
		shadow_heap[b] = t;
	endtask

	task automatic climb(input int pos);
		int par;
		while (pos > 0) begin
			par = (pos - 1) / 2;
			if (!(shadow_heap[pos] > shadow_heap[par]))
				break;
			swap_slots(pos, par);
			pos = par;
		end
	endtask

	task automatic sink(input int pos, input int size);
		int l;
		int r;
		int big;
		forever begin
			l = 2 * pos + 1;
			r = 2 * pos + 2;
			big = pos;
			if (l < size && shadow_heap[l] > shadow_heap[big])
				big = l;
			if (r < size && shadow_heap[r] > shadow_heap[big])
				big = r;
			if (big == pos)
				break;
			swap_slots(pos, big);
			pos = big;
		end
	endtask

	function automatic heap_result_t make_result(logic [1:0] st, logic [31:0] item,
			logic fin);
		heap_result_t r;
		r.status = st;
		r.item_value = item;
		r.entry_count = shadow_fill[5:0];
		r.last = fin;
		return r;
	endfunction

	task automatic queue_result(input heap_result_t r);
		pending_results = {pending_results, r};
	endtask

	task automatic predict_heap(input logic [1:0] req, input logic signed [31:0] val);
		int hit;
		int n;
		if (req == mhds_pkg::REQ_INSERT) begin
			if (shadow_fill >= DEPTH) begin
				queue_result(make_result(mhds_pkg::ST_FULL, 0, 1'b1));
			end else begin
				shadow_heap[shadow_fill] = val;
				shadow_fill++;
				climb(shadow_fill - 1);
				queue_result(make_result(mhds_pkg::ST_OK, 0, 1'b1));
			end
		end else if (req == mhds_pkg::REQ_DELETE) begin
			hit = -1;
			for (int i = 0; i < shadow_fill; i++) begin
				if (shadow_heap[i] == val) begin
					hit = i;
					break;
				end
			end
			if (hit < 0) begin
				queue_result(make_result(mhds_pkg::ST_NOTFOUND, 0, 1'b1));
			end else begin
				swap_slots(hit, shadow_fill - 1);
				shadow_fill--;
				if (hit < shadow_fill) begin
					sink(hit, shadow_fill);
					climb(hit);
				end
				queue_result(make_result(mhds_pkg::ST_OK, 0, 1'b1));
			end
		end else if (req == mhds_pkg::REQ_SORT) begin
			n = shadow_fill;
			if (n == 0) begin
				queue_result(make_result(mhds_pkg::ST_EMPTY, 0, 1'b1));
			end else begin
				for (int i = n / 2; i > 0; i--)
					sink(i - 1, n);
				for (int i = n - 1; i >= 1; i--) begin
					swap_slots(0, i);
					sink(0, i);
				end
				for (int i = 0; i < n; i++)
					queue_result(make_result(mhds_pkg::ST_OK, shadow_heap[i],
						i + 1 == n));
			end
		end else begin
			queue_result(make_result(mhds_pkg::ST_OK, 0, 1'b1));
		end
	endtask

	task automatic send_request(input logic [1:0] req, input logic signed [31:0] val);
		int gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		value <= val;
		do @(posedge clk); while (in_stall);
		predict_heap(req, val);
	endtask

	always @(posedge clk) begin
		if (!arst_n || !idle_enable) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= (stall_left != 0);
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 8);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		heap_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected beat status=%0d item=%0d count=%0d last=%0b",
					$time, status, item_value, entry_count, last);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, status);
					errors++;
				end
				if (item_value !== want.item_value) begin
					$display("%0t: item_value expected %0d actual %0d", $time,
						$signed(want.item_value), item_value);
					errors++;
				end
				if (entry_count !== want.entry_count) begin
					$display("%0t: entry_count expected %0d actual %0d", $time,
						want.entry_count, entry_count);
					errors++;
				end
				if (last !== want.last) begin
					$display("%0t: last expected %0b actual %0b", $time,
						want.last, last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed(32'($urandom_range(0, 15))) - 8;
			2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed(32'($urandom_range(0, 63))) - 32;
		endcase
	endfunction

	function automatic logic signed [31:0] stored_value();
		if (shadow_fill == 0)
			return pick_value();
		return shadow_heap[$urandom_range(0, shadow_fill - 1)];
	endfunction

	task automatic test_directed();
		send_request(mhds_pkg::REQ_SORT, 0);
		send_request(mhds_pkg::REQ_DELETE, 5);
		send_request(REQ_UNUSED, 32'sh7fffffff);
		send_request(mhds_pkg::REQ_INSERT, 32'sh7fffffff);
		send_request(mhds_pkg::REQ_INSERT, 32'sh80000000);
		send_request(mhds_pkg::REQ_INSERT, 0);
		send_request(mhds_pkg::REQ_INSERT, -1);
		send_request(mhds_pkg::REQ_INSERT, 32'sh55555555);
		send_request(mhds_pkg::REQ_INSERT, 32'shaaaaaaaa);
		send_request(mhds_pkg::REQ_DELETE, 32'sh80000000);
		send_request(mhds_pkg::REQ_DELETE, 32'sh7fffffff);
		send_request(mhds_pkg::REQ_DELETE, 1234);
		send_request(mhds_pkg::REQ_SORT, 0);
		send_request(mhds_pkg::REQ_DELETE, shadow_heap[shadow_fill - 1]);
		send_request(mhds_pkg::REQ_SORT, 0);
	endtask

	task automatic test_full_store();
		while (shadow_fill < DEPTH)
			send_request(mhds_pkg::REQ_INSERT, pick_value());
		send_request(mhds_pkg::REQ_INSERT, 7);
		send_request(mhds_pkg::REQ_SORT, 0);
		while (shadow_fill > 0)
			send_request(mhds_pkg::REQ_DELETE, stored_value());
		send_request(mhds_pkg::REQ_SORT, 0);
	endtask

	task automatic test_random(input int count);
		int roll;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 50)
				send_request(mhds_pkg::REQ_INSERT, pick_value());
			else if (roll < 80)
				send_request(mhds_pkg::REQ_DELETE, $urandom_range(0, 4) == 0
					? pick_value() : stored_value());
			else if (roll < 95)
				send_request(mhds_pkg::REQ_SORT, $urandom);
			else
				send_request(REQ_UNUSED, $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = mhds_pkg::REQ_INSERT;
		value = 0;
		errors = 0;
		cycle_count = 0;
		shadow_fill = 0;
		idle_enable = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_store();
		test_random(230);
		idle_enable = 1'b0;
		test_random(40);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
